@@ hdl/dss_pkg.sv @@
// Shared types, codes and helper functions for the dual stepper step sequencer.
// Used by dss_lane and dual_stepper_step_sequencer; depends on nothing else.

package dss_pkg;

    // Default step period width in bits
    localparam int PERIOD_BITS_DEF = 24;

    // Timebase and step counter width
    localparam int TIME_BITS = 32;

    // Configuration register width and reset values
    localparam int            CFG_BITS          = 8;
    localparam logic [7:0]    DUTY_RESET        = 8'd204;
    localparam logic [7:0]    PHASE_ORDER_RESET = 8'd228;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_SPARE = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic {
        REG_DUTY        = 1'b0,
        REG_PHASE_ORDER = 1'b1
    } cfg_index_t;

    // Coil polarity codes (2-bit two's complement)
    localparam logic signed [1:0] COIL_POS = 2'sb01;
    localparam logic signed [1:0] COIL_NEG = 2'sb11;
    localparam logic signed [1:0] COIL_OFF = 2'sb00;

    // Per-beat control handed to each motor lane
    typedef struct packed {
        logic tick;
        logic set;
        logic stop;
        logic refresh;
    } lane_ctl_t;

    // What a lane reports for the current beat
    typedef struct packed {
        logic              stepped;
        logic signed [1:0] coil_a;
        logic signed [1:0] coil_b;
    } lane_out_t;

    // Phase shown for a step index under a phase order
    function automatic logic [1:0] map_phase(input logic [7:0] order, input logic [1:0] idx);
        return order[{idx, 1'b0} +: 2];
    endfunction

    // True when all four 2-bit entries are distinct
    function automatic logic is_permutation(input logic [7:0] order);
        logic [3:0] seen;
        seen = 4'b0000;
        for (int i = 0; i < 4; i++)
        begin
            seen[order[2*i +: 2]] = 1'b1;
        end
        return (seen == 4'b1111);
    endfunction

    // Coil polarities {a, b} for a phase
    function automatic logic [3:0] coil_pair(input logic [1:0] phase);
        logic [3:0] pair;
        case (phase)
            2'd0:    pair = {COIL_POS, COIL_POS};
            2'd1:    pair = {COIL_NEG, COIL_POS};
            2'd2:    pair = {COIL_NEG, COIL_NEG};
            2'd3:    pair = {COIL_POS, COIL_NEG};
            default: pair = {COIL_OFF, COIL_OFF};
        endcase
        return pair;
    endfunction

endpackage

@@ hdl/dual_stepper_step_sequencer.sv @@
// Top level of the dual stepper full-step sequencer: two motor lanes, step count
// merge and a two-entry output buffer. Depends on dss_pkg and dss_lane.
//
// Usage:
//   Input stream (s_tvalid/s_tready/s_tdata) carries one command per beat:
//   a one-microsecond tick, a drive update with both motors' period and
//   direction, or a stop that halts both motors and clears the step count.
//   Output stream (m_tvalid/m_tready/m_tdata) returns exactly one beat per
//   input beat: the four coil polarities, the two stepped flags and the
//   running step total.
//   Configuration port (cfg_wr_en/cfg_addr/cfg_wdata) writes duty_level
//   (index 0) and phase_order (index 1); a phase order that is not a
//   permutation is dropped. Write only while no beat is in flight.
//   Results are registered in the output entry, or in the skid entry when
//   that is full. Throughput: one beat per cycle while s_tready is high;
//   both motors are evaluated in the same cycle by their own lane.
//   Stall: a two-entry output buffer holds results; s_tready drops only when
//   both entries are full, and no result is lost or repeated.
//   Reset (rst_n low, asynchronous): time, step count and both lanes clear,
//   motors stopped, duty 204, phase order 228, output buffer empty.

module dual_stepper_step_sequencer
    import dss_pkg::*;
#(
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // s_tdata fields, low bit up: cmd[2], left_period[PERIOD_BITS],
    // left_reverse[1], right_period[PERIOD_BITS], right_reverse[1], zero fill
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [((4+2*PERIOD_BITS+7)/8)*8-1:0] s_tdata,
    // m_tdata fields, low bit up: left_coil_a[2], left_coil_b[2], right_coil_a[2],
    // right_coil_b[2], left_stepped[1], right_stepped[1], step_total[32], zero fill
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  cfg_index_t           cfg_addr,
    input  logic [CFG_BITS-1:0]  cfg_wdata
);

    localparam int LP_LO     = 2;
    localparam int LR_POS    = LP_LO + PERIOD_BITS;
    localparam int RP_LO     = LR_POS + 1;
    localparam int RR_POS    = RP_LO + PERIOD_BITS;
    localparam int OUT_W     = 48;
    localparam int RES_BITS  = 10 + TIME_BITS;

    cmd_t                   cmd;
    logic                   accept;
    logic                   pop;
    lane_ctl_t              ctl;
    lane_out_t              left_out;
    lane_out_t              right_out;

    logic [TIME_BITS-1:0]   time_reg,  time_next;
    logic [TIME_BITS-1:0]   time_inc;
    logic [TIME_BITS-1:0]   count_reg, count_next;
    logic [CFG_BITS-1:0]    duty_reg,  duty_next;
    logic [CFG_BITS-1:0]    order_reg, order_next;
    logic                   refresh;

    logic [OUT_W-1:0]       result;
    logic [OUT_W-1:0]       out_reg,   out_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]       skid_reg,  skid_next;
    logic                   skid_valid_reg, skid_valid_next;

    // Input decode
    assign cmd      = cmd_t'(s_tdata[1:0]);
    assign accept   = s_tvalid && s_tready;
    assign time_inc = time_reg + 32'd1;

    always_comb
    begin
        ctl         = '0;
        ctl.refresh = refresh;
        if (accept)
        begin
            case (cmd)
                CMD_TICK:  ctl.tick = 1'b1;
                CMD_SET:   ctl.set  = 1'b1;
                CMD_STOP:  ctl.stop = 1'b1;
                default:   ctl      = '0;
            endcase
        end
    end

    // Configuration registers; any accepted write raises refresh for the lanes
    always_comb
    begin
        duty_next  = duty_reg;
        order_next = order_reg;
        refresh    = 1'b0;
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_DUTY:
                begin
                    duty_next = cfg_wdata;
                    refresh   = 1'b1;
                end
                REG_PHASE_ORDER:
                begin
                    if (is_permutation(cfg_wdata))
                    begin
                        order_next = cfg_wdata;
                        refresh    = 1'b1;
                    end
                end
                default:
                begin
                    refresh = 1'b0;
                end
            endcase
        end
    end

    // Motor lanes
    dss_lane #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_left (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .new_period  (s_tdata[LP_LO +: PERIOD_BITS]),
        .new_reverse (s_tdata[LR_POS]),
        .time_now    (time_reg),
        .time_inc    (time_inc),
        .phase_order (order_next),
        .duty_zero   (duty_reg == '0),
        .lane_out    (left_out)
    );

    dss_lane #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_right (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .new_period  (s_tdata[RP_LO +: PERIOD_BITS]),
        .new_reverse (s_tdata[RR_POS]),
        .time_now    (time_reg),
        .time_inc    (time_inc),
        .phase_order (order_next),
        .duty_zero   (duty_reg == '0),
        .lane_out    (right_out)
    );

    // Merge: timebase and step total
    always_comb
    begin
        time_next  = time_reg;
        count_next = count_reg;
        if (ctl.tick)
        begin
            time_next  = time_inc;
            count_next = count_reg + {31'd0, left_out.stepped} + {31'd0, right_out.stepped};
        end
        else if (ctl.stop)
        begin
            count_next = '0;
        end
    end

    assign result = OUT_W'({count_next[RES_BITS-11:0], right_out.stepped, left_out.stepped,
                            right_out.coil_b, right_out.coil_a,
                            left_out.coil_b, left_out.coil_a});

    // Two-entry output buffer
    assign s_tready = !skid_valid_reg;
    assign pop      = out_valid_reg && m_tready;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                out_next = result;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg       <= '0;
            count_reg      <= '0;
            duty_reg       <= DUTY_RESET;
            order_reg      <= PHASE_ORDER_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            time_reg       <= time_next;
            count_reg      <= count_next;
            duty_reg       <= duty_next;
            order_reg      <= order_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // Buffer fills front entry first
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a beat while output entry is empty");

    // Stop clears the step total
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == CMD_STOP)) |=> (count_reg == '0))
        else $error("step total not cleared by stop");

    // Only ticks advance the timebase
    a_time_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && (cmd == CMD_TICK)) |=> $stable(time_reg))
        else $error("timebase moved without a tick");

    // Total grows by exactly the steps taken on a tick
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == CMD_TICK)) |=>
            (count_reg == $past(count_reg) + {31'd0, $past(left_out.stepped)}
                                           + {31'd0, $past(right_out.stepped)}))
        else $error("step total does not match steps taken");

    // Configured phase order always stays a permutation
    a_order_perm: assert property (@(posedge clk) disable iff (!rst_n)
        is_permutation(order_reg))
        else $error("phase order is not a permutation");

endmodule

@@ hdl/dss_lane.sv @@
// One motor lane: step timing, step index, shown phase and coil drive.
// Depends on dss_pkg; instantiated twice by dual_stepper_step_sequencer.

module dss_lane
    import dss_pkg::*;
#(
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lane_ctl_t              ctl,
    input  logic [PERIOD_BITS-1:0] new_period,
    input  logic                   new_reverse,
    input  logic [TIME_BITS-1:0]   time_now,
    input  logic [TIME_BITS-1:0]   time_inc,
    input  logic [7:0]             phase_order,
    input  logic                   duty_zero,
    output lane_out_t              lane_out
);

    logic [TIME_BITS-1:0]   last_reg,    last_next;
    logic [PERIOD_BITS-1:0] period_reg,  period_next;
    logic                   reverse_reg, reverse_next;
    logic [1:0]             index_reg,   index_next;
    logic [1:0]             phase_reg,   phase_next;
    logic                   running;
    logic                   due;
    logic                   step_hit;
    logic [3:0]             pair;

    // Lane state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg    <= '0;
            period_reg  <= '0;
            reverse_reg <= 1'b0;
            index_reg   <= 2'd0;
            phase_reg   <= 2'd0;
        end
        else
        begin
            last_reg    <= last_next;
            period_reg  <= period_next;
            reverse_reg <= reverse_next;
            index_reg   <= index_next;
            phase_reg   <= phase_next;
        end
    end

    // Step decision and state update; elapsed time wraps modulo 2^32
    assign running = (period_reg != '0);
    assign due     = running && ((time_inc - last_reg) >= TIME_BITS'(period_reg));

    always_comb
    begin
        last_next    = last_reg;
        period_next  = period_reg;
        reverse_next = reverse_reg;
        index_next   = index_reg;
        phase_next   = phase_reg;
        step_hit     = 1'b0;
        if (ctl.tick)
        begin
            if (due)
            begin
                last_next  = time_inc;
                phase_next = map_phase(phase_order, index_reg);
                index_next = reverse_reg ? (index_reg - 2'd1) : (index_reg + 2'd1);
                step_hit   = 1'b1;
            end
        end
        else if (ctl.set)
        begin
            period_next  = new_period;
            reverse_next = new_reverse;
            // start from stopped: show phase at once, restart timing
            if ((new_period != '0) && !running)
            begin
                last_next  = time_now;
                phase_next = map_phase(phase_order, index_reg);
            end
        end
        else if (ctl.stop)
        begin
            period_next = '0;
        end
        else if (ctl.refresh && running)
        begin
            phase_next = map_phase(phase_order, index_reg);
        end
    end

    // Coil drive from the updated state
    always_comb
    begin
        if ((period_next != '0) && !duty_zero)
        begin
            pair = coil_pair(phase_next);
        end
        else
        begin
            pair = {COIL_OFF, COIL_OFF};
        end
        lane_out.stepped = step_hit;
        lane_out.coil_a  = pair[3:2];
        lane_out.coil_b  = pair[1:0];
    end

endmodule
